// ----- sv/signed_int_to_decimal_ascii_macros.svh -----
// Assertion macros for the file that carries concurrent checks.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SDTA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SDTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sdta_pkg.sv -----
package sdta_pkg;

  // Text characters.
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;

  // Conversion geometry: ten BCD digits cover a 32-bit magnitude.
  localparam int VALUE_W        = 32;
  localparam int NUM_DIGITS     = 10;
  localparam int BCD_W          = 4 * NUM_DIGITS;
  localparam int BITS_PER_STAGE = 8;
  localparam int NUM_STAGES     = VALUE_W / BITS_PER_STAGE;

  // Payload carried between conversion stages.
  typedef struct packed {
    logic               neg;
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
  } conv_t;

  // Handshake of one pipeline link.
  typedef struct packed {
    logic valid;
    logic ready;
  } link_t;

endpackage

// ----- sv/sdta_sign_stage.sv -----
module sdta_sign_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sdta_pkg::VALUE_W-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sdta_pkg::conv_t              out_data
);
  import sdta_pkg::*;

  logic  valid_r;
  conv_t data_r;
  conv_t data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // Split off the sign and form the unsigned magnitude; the most negative
  // value wraps to its own magnitude in unsigned arithmetic.
  always_comb begin
    data_nxt.neg = in_value[VALUE_W-1];
    data_nxt.bin = in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value;
    data_nxt.bcd = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- sv/sdta_dabble_stage.sv -----
module sdta_dabble_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sdta_pkg::conv_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output sdta_pkg::conv_t out_data
);
  import sdta_pkg::*;

  logic  valid_r;
  conv_t data_r;
  conv_t data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // Shift-and-add-three over a slice of the binary bits: every digit of
  // five or more is corrected before each shift into the BCD word.
  always_comb begin
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
    logic [3:0]         dig;
    bcd = in_data.bcd;
    bin = in_data.bin;
    for (int s = 0; s < BITS_PER_STAGE; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        dig = bcd[d*4 +: 4];
        if (dig >= 4'd5) begin
          bcd[d*4 +: 4] = dig + 4'd3;
        end
      end
      bcd = {bcd[BCD_W-2:0], bin[VALUE_W-1]};
      bin = {bin[VALUE_W-2:0], 1'b0};
    end
    data_nxt.neg = in_data.neg;
    data_nxt.bcd = bcd;
    data_nxt.bin = bin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- sv/sdta_serialiser.sv -----
module sdta_serialiser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sdta_pkg::conv_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_char,
  output logic            out_last
);
  import sdta_pkg::*;

  logic             busy_r;
  logic             minus_r;
  logic [3:0]       pos_r;
  logic [BCD_W-1:0] digits_r;
  logic [3:0]       lead;
  logic             out_fire;

  // Position of the most significant non-zero digit, zero when all are zero.
  always_comb begin
    lead = 4'd0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (in_data.bcd[i*4 +: 4] != 4'd0) begin
        lead = 4'(i);
      end
    end
  end

  // Present the sign first, then the digits from the leading one down.
  assign out_valid = busy_r;
  assign out_char  = minus_r ? CHAR_MINUS : (CHAR_ZERO + {4'd0, digits_r[pos_r*4 +: 4]});
  assign out_last  = !minus_r && (pos_r == 4'd0);
  assign out_fire  = busy_r && out_ready;

  // A new number loads as soon as the final character of the last one leaves.
  assign in_ready = !busy_r || (out_fire && out_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      minus_r <= 1'b0;
      pos_r   <= 4'd0;
    end else if (in_ready && in_valid) begin
      busy_r  <= 1'b1;
      minus_r <= in_data.neg;
      pos_r   <= lead;
    end else if (out_fire) begin
      if (minus_r) begin
        minus_r <= 1'b0;
      end else if (pos_r == 4'd0) begin
        busy_r <= 1'b0;
      end else begin
        pos_r <= pos_r - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      digits_r <= in_data.bcd;
    end
  end

endmodule

// ----- sv/signed_int_to_decimal_ascii.sv -----
// Channel  Direction  tdata (low bit up)         tuser / tlast
// in_      slave      [31:0] value (signed)      none
// out_     master     [7:0]  char_code           tlast = last_char
//
// A number passes a sign stage and four shift-add-three stages of eight bits
// each before the character stage offers its first character.
// The character stage sends one beat per cycle while out_tready is high, so
// a number's text of 1 to 11 characters leaves one character per beat.
// Reset clears the valid bits and the character position; no stage needs a clearing pass.
// A stall on the output holds every stage that holds a number, and no beat is lost or repeated.
`include "signed_int_to_decimal_ascii_macros.svh"

module signed_int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic signed [31:0] in_tdata,   // [31:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,         // [7:0] char_code
  output logic        out_tlast
);
  import sdta_pkg::*;

  link_t link      [NUM_STAGES+1];
  conv_t link_data [NUM_STAGES+1];

  // Sign and magnitude.
  sdta_sign_stage u_sign (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_value  (in_tdata),
    .out_valid (link[0].valid),
    .out_ready (link[0].ready),
    .out_data  (link_data[0])
  );

  // Binary to BCD, eight bits per stage.
  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_dabble
    sdta_dabble_stage u_dabble (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (link[g].valid),
      .in_ready  (link[g].ready),
      .in_data   (link_data[g]),
      .out_valid (link[g+1].valid),
      .out_ready (link[g+1].ready),
      .out_data  (link_data[g+1])
    );
  end

  // One character per beat.
  sdta_serialiser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (link[NUM_STAGES].valid),
    .in_ready  (link[NUM_STAGES].ready),
    .in_data   (link_data[NUM_STAGES]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_tdata),
    .out_last  (out_tlast)
  );

  // Character classes and mid-run beats seen on the output.
  logic out_is_minus;
  logic out_is_digit;
  logic out_mid_beat;

  assign out_is_minus = (out_tdata == CHAR_MINUS);
  assign out_is_digit = (out_tdata >= CHAR_ZERO) && (out_tdata <= CHAR_ZERO + 8'd9);
  assign out_mid_beat = out_tvalid && out_tready && !out_tlast;

  // Checks on the character stream.
  `SDTA_ASSERT_SAME(a_minus_not_last, out_tvalid && out_is_minus, !out_tlast, "sign marked last")
  `SDTA_ASSERT_SAME(a_char_legal, out_tvalid, out_is_minus || out_is_digit, "illegal character")
  `SDTA_ASSERT_NEXT(a_run_continues, out_mid_beat, out_tvalid, "run broken before last character")

endmodule
